// ===== sv/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the block buffer cache controller
// Opcodes, default sizes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned SlotCountDefault = 30;
  localparam int unsigned BlockBitsDefault = 16;
  localparam int unsigned SlotIdxW = 5;
  localparam int unsigned BlockOutW = 16;
  localparam int unsigned DeviceW = 8;
  localparam int unsigned CountW = 8;

  typedef enum logic [1:0] {
    OpGet     = 2'd0,
    OpDirty   = 2'd1,
    OpRelease = 2'd2,
    OpSync    = 2'd3
  } opcode_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic lookup;     // register hit and free search
    logic get_commit; // update slot for the get
    logic dirty_set;
    logic release_dec;
    logic sync_clear; // clear dirty bit of the sync cursor slot
    logic sync_step;  // advance sync cursor
    logic sync_start;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sync_found; // cursor slot is valid and dirty
    logic sync_end;   // cursor at final slot
  } dp_status_t;

endpackage

// ===== sv/bbc_if.sv =====
// ----------------------------------------------------------------------------
// bbc_req_if / bbc_rsp_if: valid/ready channels of the cache controller
// Request and result transactions with source and sink modports.
// ----------------------------------------------------------------------------
interface bbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  device;
  logic [15:0] block_number;
  logic [4:0]  slot;
  modport source (output valid, opcode, device, block_number, slot, input ready);
  modport sink (input valid, opcode, device, block_number, slot, output ready);
endinterface

interface bbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  slot_index;
  logic        hit;
  logic        no_free_slot;
  logic        fill_request;
  logic [15:0] fill_block;
  logic        writeback_request;
  logic [15:0] writeback_block;
  logic        last;
  modport source (output valid, slot_index, hit, no_free_slot, fill_request, fill_block,
                  writeback_request, writeback_block, last, input ready);
  modport sink (input valid, slot_index, hit, no_free_slot, fill_request, fill_block,
                writeback_request, writeback_block, last, output ready);
endinterface

// ===== sv/bbc_datapath.sv =====
// ----------------------------------------------------------------------------
// bbc_datapath: slot metadata and result formation
// Holds per-slot state, runs the tag match and first-free search in a
// registered stage, and forms the result payload.
// ----------------------------------------------------------------------------
module bbc_datapath #(
  parameter int unsigned SlotCount = bbc_pkg::SlotCountDefault,
  parameter int unsigned BlockBits = bbc_pkg::BlockBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bbc_pkg::dp_cmd_t                    cmd_i,
  output bbc_pkg::dp_status_t                 status_o,
  input  logic [bbc_pkg::DeviceW-1:0]         device_i,
  input  logic [bbc_pkg::BlockOutW-1:0]       block_number_i,
  input  logic [bbc_pkg::SlotIdxW-1:0]        slot_i,
  output logic [bbc_pkg::SlotIdxW-1:0]        slot_index_o,
  output logic                                hit_o,
  output logic                                no_free_slot_o,
  output logic                                fill_request_o,
  output logic [bbc_pkg::BlockOutW-1:0]       fill_block_o,
  output logic                                writeback_request_o,
  output logic [bbc_pkg::BlockOutW-1:0]       writeback_block_o
);
  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW = bbc_pkg::CountW;
  localparam int unsigned OutW = bbc_pkg::BlockOutW;

  logic [SlotCount-1:0]                 valid_q, dirty_q;
  logic [bbc_pkg::DeviceW-1:0]          dev_tag_q [SlotCount];
  logic [BlockBits-1:0]                 blk_tag_q [SlotCount];
  logic [CntW-1:0]                      cnt_q [SlotCount];

  logic [bbc_pkg::DeviceW-1:0]          dev_q;
  logic [BlockBits-1:0]                 blk_q;
  logic [bbc_pkg::SlotIdxW-1:0]         slot_q;
  logic                                 hit_q, free_q;
  logic [IdxW-1:0]                      hit_idx_q, free_idx_q, cur_q;

  // search over slots
  logic                                 hit_d, free_d;
  logic [IdxW-1:0]                      hit_idx_d, free_idx_d;
  always_comb begin
    hit_d = 1'b0;
    free_d = 1'b0;
    hit_idx_d = '0;
    free_idx_d = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (valid_q[i] && dev_tag_q[i] == dev_q && blk_tag_q[i] == blk_q) begin
        hit_d = 1'b1;
        hit_idx_d = IdxW'(i);
      end
      if (cnt_q[i] == '0) begin
        free_d = 1'b1;
        free_idx_d = IdxW'(i);
      end
    end
  end

  logic slot_ok;
  assign slot_ok = 32'(slot_q) < SlotCount;
  logic [IdxW-1:0] sidx;
  assign sidx = IdxW'(slot_q);

  assign status_o.sync_found = valid_q[cur_q] && dirty_q[cur_q];
  assign status_o.sync_end   = 32'(cur_q) == SlotCount - 1;

  // request capture, search registers, cursor
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dev_q  <= device_i;
      blk_q  <= BlockBits'(block_number_i);
      slot_q <= slot_i;
    end
    if (cmd_i.lookup) begin
      hit_q <= hit_d;
      free_q <= free_d;
      hit_idx_q <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
    if (cmd_i.sync_start) cur_q <= '0;
    else if (cmd_i.sync_step) cur_q <= cur_q + 1'b1;
  end

  // tag storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.get_commit && !hit_q && free_q) begin
      dev_tag_q[free_idx_q] <= dev_q;
      blk_tag_q[free_idx_q] <= blk_q;
    end
  end

  // control state per slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < SlotCount; i++) cnt_q[i] <= '0;
    end else begin
      if (cmd_i.get_commit) begin
        if (hit_q) begin
          if (cnt_q[hit_idx_q] != '1) cnt_q[hit_idx_q] <= cnt_q[hit_idx_q] + 1'b1;
        end else if (free_q) begin
          valid_q[free_idx_q] <= 1'b1;
          dirty_q[free_idx_q] <= 1'b0;
          cnt_q[free_idx_q] <= CntW'(1);
        end
      end
      if (cmd_i.dirty_set && slot_ok) dirty_q[sidx] <= 1'b1;
      if (cmd_i.release_dec && slot_ok && cnt_q[sidx] != '0)
        cnt_q[sidx] <= cnt_q[sidx] - 1'b1;
      if (cmd_i.sync_clear) dirty_q[cur_q] <= 1'b0;
    end
  end

  // payloads: get result from search registers, sync from cursor
  logic get_wb;
  assign get_wb = valid_q[free_idx_q] && dirty_q[free_idx_q];
  always_comb begin
    slot_index_o = '0;
    hit_o = 1'b0;
    no_free_slot_o = 1'b0;
    fill_request_o = 1'b0;
    fill_block_o = '0;
    writeback_request_o = 1'b0;
    writeback_block_o = '0;
    if (cmd_i.sync_clear) begin
      slot_index_o = bbc_pkg::SlotIdxW'(cur_q);
      writeback_request_o = 1'b1;
      writeback_block_o = OutW'(blk_tag_q[cur_q]);
    end else if (hit_q) begin
      slot_index_o = bbc_pkg::SlotIdxW'(hit_idx_q);
      hit_o = 1'b1;
    end else if (free_q) begin
      slot_index_o = bbc_pkg::SlotIdxW'(free_idx_q);
      fill_request_o = 1'b1;
      fill_block_o = OutW'(blk_q);
      writeback_request_o = get_wb;
      writeback_block_o = get_wb ? OutW'(blk_tag_q[free_idx_q]) : '0;
    end else begin
      no_free_slot_o = 1'b1;
    end
  end
endmodule

// ===== sv/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbc_ctrl: request sequencer
// Accepts one request at a time, drives datapath commands and owns the
// result valid, sync and last flags.
// ----------------------------------------------------------------------------
module bbc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [1:0]                    opcode_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic                          rsp_sync_o,   // result register holds sync transaction
  output logic                          rsp_last_o,
  output bbc_pkg::dp_cmd_t              cmd_o,
  input  bbc_pkg::dp_status_t           status_i,
  input  logic                          dp_ready_i    // gates request ready; tied high in top
);
  typedef enum logic [2:0] {
    StIdle, StLookup, StGet, StSync, StSyncOut, StDone, StOut
  } state_e;

  state_e state_q;
  logic [1:0] op_q;
  logic rsp_valid_q, rsp_sync_q, rsp_last_q;

  assign req_ready_o = (state_q == StIdle) && dp_ready_i;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_sync_o = rsp_sync_q;
  assign rsp_last_o = rsp_last_q;

  logic acc, out_done;
  assign acc = req_valid_i && req_ready_o;
  assign out_done = rsp_valid_q && rsp_ready_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = acc;
    case (state_q)
      StLookup: begin
        case (bbc_pkg::opcode_e'(op_q))
          bbc_pkg::OpGet:     cmd_o.lookup = 1'b1;
          bbc_pkg::OpDirty:   cmd_o.dirty_set = 1'b1;
          bbc_pkg::OpRelease: cmd_o.release_dec = 1'b1;
          default:            cmd_o.sync_start = 1'b1;
        endcase
      end
      StGet: cmd_o.get_commit = 1'b1;
      StSync: begin
        if (status_i.sync_found) cmd_o.sync_clear = 1'b1;
        else if (!status_i.sync_end) cmd_o.sync_step = 1'b1;
      end
      StSyncOut: if (out_done && !status_i.sync_end) cmd_o.sync_step = 1'b1;
      default: ;
    endcase
  end

  // state and result register control; payload captured in top
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q <= '0;
      rsp_valid_q <= 1'b0;
      rsp_sync_q <= 1'b0;
      rsp_last_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (acc) begin
          op_q <= opcode_i;
          state_q <= StLookup;
        end
        StLookup: begin
          case (bbc_pkg::opcode_e'(op_q))
            bbc_pkg::OpGet:  state_q <= StGet;
            bbc_pkg::OpSync: state_q <= StSync;
            default:         state_q <= StIdle;
          endcase
        end
        StGet: begin
          rsp_valid_q <= 1'b1;
          rsp_sync_q <= 1'b0;
          rsp_last_q <= 1'b1;
          state_q <= StOut;
        end
        StSync: begin
          if (status_i.sync_found) begin
            rsp_valid_q <= 1'b1;
            rsp_sync_q <= 1'b1;
            rsp_last_q <= 1'b0;
            state_q <= StSyncOut;
          end else if (status_i.sync_end) begin
            state_q <= StDone;
          end
        end
        StSyncOut: if (out_done) begin
          rsp_valid_q <= 1'b0;
          state_q <= status_i.sync_end ? StDone : StSync;
        end
        StDone: begin
          rsp_valid_q <= 1'b1;
          rsp_sync_q <= 1'b0;
          rsp_last_q <= 1'b1;
          state_q <= StOut;
        end
        StOut: if (out_done) begin
          rsp_valid_q <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== sv/block_buffer_cache_controller.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_controller: buffer cache metadata controller
// Tracks slot tags, dirty bits and reference counts; tells an external mover
// which blocks to fill and write back.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (sink): opcode get / mark dirty / release / sync, with device,
//   block number and slot. res channel (source): one transaction per get,
//   one per written-back slot during sync plus a final done transaction.
//   Requests are handled one at a time. Mark dirty and release give no
//   result. A get offers its result after a registered tag match and
//   first-free search over all slots and then a commit; the next request
//   is taken only once the result has been taken.
//   Sync walks the slot cursor one slot per cycle, pausing at each dirty slot
//   until its result is taken.
//   Reset clears valid, dirty and counts at once; no clearing pass.
//   When the receiver stalls, the result register holds and the walk waits.
// ----------------------------------------------------------------------------
module block_buffer_cache_controller #(
  parameter int unsigned SlotCount = bbc_pkg::SlotCountDefault,
  parameter int unsigned BlockBits = bbc_pkg::BlockBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bbc_req_if.sink  req_i,
  bbc_rsp_if.source res_o
);
  bbc_pkg::dp_cmd_t    cmd;
  bbc_pkg::dp_status_t status;
  logic rsp_sync, rsp_last;

  logic [bbc_pkg::SlotIdxW-1:0]  slot_index;
  logic hit, no_free, fill_req, wb_req;
  logic [bbc_pkg::BlockOutW-1:0] fill_blk, wb_blk;

  bbc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .opcode_i    (req_i.opcode),
    .rsp_valid_o (res_o.valid),
    .rsp_ready_i (res_o.ready),
    .rsp_sync_o  (rsp_sync),
    .rsp_last_o  (rsp_last),
    .cmd_o       (cmd),
    .status_i    (status),
    .dp_ready_i  (1'b1)
  );

  bbc_datapath #(.SlotCount(SlotCount), .BlockBits(BlockBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i               (cmd),
    .status_o            (status),
    .device_i            (req_i.device),
    .block_number_i      (req_i.block_number),
    .slot_i              (req_i.slot),
    .slot_index_o        (slot_index),
    .hit_o               (hit),
    .no_free_slot_o      (no_free),
    .fill_request_o      (fill_req),
    .fill_block_o        (fill_blk),
    .writeback_request_o (wb_req),
    .writeback_block_o   (wb_blk)
  );

  // result payload register, loaded when a get commits or a sync slot clears
  logic [bbc_pkg::SlotIdxW-1:0]  slot_q;
  logic hit_q, nofree_q, fill_q, wb_q;
  logic [bbc_pkg::BlockOutW-1:0] fblk_q, wblk_q;
  always_ff @(posedge clk_i) begin
    if (cmd.get_commit || cmd.sync_clear) begin
      slot_q <= slot_index;
      hit_q <= hit;
      nofree_q <= no_free;
      fill_q <= fill_req;
      fblk_q <= fill_blk;
      wb_q <= wb_req;
      wblk_q <= wb_blk;
    end
  end

  // done transaction of a sync carries only last
  logic gsel_q;
  logic done;
  assign done = rsp_last && !rsp_sync && !gsel_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gsel_q <= 1'b0;
    else if (cmd.get_commit) gsel_q <= 1'b1;
    else if (cmd.sync_start) gsel_q <= 1'b0;
  end

  assign res_o.slot_index        = done ? '0 : slot_q;
  assign res_o.hit               = done ? 1'b0 : hit_q;
  assign res_o.no_free_slot      = done ? 1'b0 : nofree_q;
  assign res_o.fill_request      = done ? 1'b0 : fill_q;
  assign res_o.fill_block        = done ? '0 : fblk_q;
  assign res_o.writeback_request = done ? 1'b0 : wb_q;
  assign res_o.writeback_block   = done ? '0 : wblk_q;
  assign res_o.last              = rsp_last;
endmodule

// ===== test/block_buffer_cache_checker.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_checker: result predictor and comparator
// Watches the request and result channels of the cache controller, keeps its
// own copy of the slot metadata, and compares each result with the oldest
// predicted one. Hands the number of failures to the test top.
// ----------------------------------------------------------------------------
module block_buffer_cache_checker #(
  parameter int unsigned SlotCount = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [1:0]  req_opcode_i,
  input  logic [7:0]  req_device_i,
  input  logic [15:0] req_block_i,
  input  logic [4:0]  req_slot_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [4:0]  res_slot_index_i,
  input  logic        res_hit_i,
  input  logic        res_no_free_i,
  input  logic        res_fill_i,
  input  logic [15:0] res_fill_block_i,
  input  logic        res_wb_i,
  input  logic [15:0] res_wb_block_i,
  input  logic        res_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o,
  output int          hit_count_o,
  output int          wb_count_o,
  output int          no_free_count_o
);

  typedef struct packed {
    logic [4:0]  slot_index;
    logic        hit;
    logic        no_free_slot;
    logic        fill_request;
    logic [15:0] fill_block;
    logic        writeback_request;
    logic [15:0] writeback_block;
    logic        last;
  } cache_result_t;

  // shadow slot metadata
  logic        valid_q  [SlotCount];
  logic        dirty_q  [SlotCount];
  logic [7:0]  dev_q    [SlotCount];
  logic [15:0] tag_q    [SlotCount];
  logic [7:0]  count_q  [SlotCount];

  cache_result_t expected_results[$];

  function automatic cache_result_t blank_result();
    cache_result_t r;
    r = '0;
    return r;
  endfunction

  // apply one request to the shadow state and queue the results it causes
  task automatic predict_request(input bbc_pkg::opcode_e op, input logic [7:0] dev,
                                 input logic [15:0] blk, input logic [4:0] slot);
    cache_result_t r;
    bit done;
    done = 0;
    case (op)
      bbc_pkg::OpGet: begin
        r = blank_result();
        r.last = 1'b1;
        for (int i = 0; i < SlotCount && !done; i++) begin
          if (valid_q[i] && dev_q[i] == dev && tag_q[i] == blk) begin
            if (count_q[i] != 8'hFF) count_q[i]++;
            r.slot_index = i[4:0];
            r.hit = 1'b1;
            done = 1;
          end
        end
        for (int i = 0; i < SlotCount && !done; i++) begin
          if (count_q[i] == 8'd0) begin
            if (valid_q[i] && dirty_q[i]) begin
              r.writeback_request = 1'b1;
              r.writeback_block = tag_q[i];
            end
            dev_q[i] = dev;
            tag_q[i] = blk;
            valid_q[i] = 1'b1;
            dirty_q[i] = 1'b0;
            count_q[i] = 8'd1;
            r.slot_index = i[4:0];
            r.fill_request = 1'b1;
            r.fill_block = blk;
            done = 1;
          end
        end
        if (!done) r.no_free_slot = 1'b1;
        expected_results.push_back(r);
      end
      bbc_pkg::OpDirty: if (slot < SlotCount) dirty_q[slot] = 1'b1;
      bbc_pkg::OpRelease: if (slot < SlotCount && count_q[slot] != 8'd0) count_q[slot]--;
      default: begin
        for (int i = 0; i < SlotCount; i++) begin
          if (valid_q[i] && dirty_q[i]) begin
            r = blank_result();
            r.slot_index = i[4:0];
            r.writeback_request = 1'b1;
            r.writeback_block = tag_q[i];
            expected_results.push_back(r);
            dirty_q[i] = 1'b0;
          end
        end
        r = blank_result();
        r.last = 1'b1;
        expected_results.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        valid_q[i] = 1'b0;
        dirty_q[i] = 1'b0;
        dev_q[i]   = '0;
        tag_q[i]   = '0;
        count_q[i] = '0;
      end
      expected_results.delete();
      fail_count_o = 0;
      result_count_o = 0;
      hit_count_o = 0;
      wb_count_o = 0;
      no_free_count_o = 0;
    end else begin
      // results first: a result never belongs to the request taken this edge
      if (res_valid_i && res_ready_i) begin
        result_count_o++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction at slot %0d", res_slot_index_i);
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          if (e.hit) hit_count_o++;
          if (e.writeback_request) wb_count_o++;
          if (e.no_free_slot) no_free_count_o++;
          check_field("slot_index", e.slot_index, res_slot_index_i);
          check_field("hit", e.hit, res_hit_i);
          check_field("no_free_slot", e.no_free_slot, res_no_free_i);
          check_field("fill_request", e.fill_request, res_fill_i);
          check_field("fill_block", e.fill_block, res_fill_block_i);
          check_field("writeback_request", e.writeback_request, res_wb_i);
          check_field("writeback_block", e.writeback_block, res_wb_block_i);
          check_field("last", e.last, res_last_i);
        end
      end
      if (req_valid_i && req_ready_i)
        predict_request(bbc_pkg::opcode_e'(req_opcode_i), req_device_i, req_block_i,
                        req_slot_i);
    end
  end

endmodule

// ===== test/block_buffer_cache_controller_test.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_controller_test: stimulus and verdict
// Drives directed and random cache requests through the controller under
// several idle/stall patterns; a checker beside the block scores the results.
// ----------------------------------------------------------------------------
module block_buffer_cache_controller_test;

  localparam int unsigned SlotCount = 30;

  logic clk_i;
  logic rst_ni;
  int   idle_pct;
  int   stall_pct;
  int   fail_count;
  int   pending;
  int   result_count;
  int   hit_count;
  int   wb_count;
  int   no_free_count;
  int   sent_count;

  bbc_req_if req_if ();
  bbc_rsp_if res_if ();

  block_buffer_cache_controller #(
    .SlotCount(SlotCount),
    .BlockBits(16)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  block_buffer_cache_checker #(.SlotCount(SlotCount)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_if.valid),
    .req_ready_i     (req_if.ready),
    .req_opcode_i    (req_if.opcode),
    .req_device_i    (req_if.device),
    .req_block_i     (req_if.block_number),
    .req_slot_i      (req_if.slot),
    .res_valid_i     (res_if.valid),
    .res_ready_i     (res_if.ready),
    .res_slot_index_i(res_if.slot_index),
    .res_hit_i       (res_if.hit),
    .res_no_free_i   (res_if.no_free_slot),
    .res_fill_i      (res_if.fill_request),
    .res_fill_block_i(res_if.fill_block),
    .res_wb_i        (res_if.writeback_request),
    .res_wb_block_i  (res_if.writeback_block),
    .res_last_i      (res_if.last),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .result_count_o  (result_count),
    .hit_count_o     (hit_count),
    .wb_count_o      (wb_count),
    .no_free_count_o (no_free_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall, changed at the falling edge
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one request transaction; idle gaps are taken before raising valid
  task automatic send_request(input bbc_pkg::opcode_e op, input logic [7:0] dev,
                              input logic [15:0] blk, input logic [4:0] slot);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.device       <= dev;
    req_if.block_number <= blk;
    req_if.slot         <= slot;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    sent_count++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // random request biased toward a small pool of blocks so hits and reuse occur
  task automatic random_request();
    int unsigned pick;
    logic [7:0]  dev;
    logic [15:0] blk;
    pick = $urandom_range(99);
    dev = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1));
    blk = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    if (pick < 45)      send_request(bbc_pkg::OpGet, dev, blk, 5'($urandom));
    else if (pick < 65) send_request(bbc_pkg::OpDirty, 8'($urandom), 16'($urandom),
                                     5'($urandom_range(31)));
    else if (pick < 92) send_request(bbc_pkg::OpRelease, 8'($urandom), 16'($urandom),
                                     5'($urandom_range(31)));
    else                send_request(bbc_pkg::OpSync, 8'($urandom), 16'($urandom),
                                     5'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sent_count = 0;
    req_if.valid = 1'b0;
    req_if.opcode = bbc_pkg::OpGet;
    req_if.device = '0;
    req_if.block_number = '0;
    req_if.slot = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty sync, miss, hit, dirty + sync, field extremes
    send_request(bbc_pkg::OpSync, 8'h00, 16'h0000, 5'd0);
    send_request(bbc_pkg::OpGet, 8'hFF, 16'hFFFF, 5'd31);
    send_request(bbc_pkg::OpGet, 8'hFF, 16'hFFFF, 5'd0);
    send_request(bbc_pkg::OpGet, 8'h00, 16'h0000, 5'd0);
    send_request(bbc_pkg::OpDirty, 8'h00, 16'h0000, 5'd0);
    send_request(bbc_pkg::OpDirty, 8'h00, 16'h0000, 5'd1);
    send_request(bbc_pkg::OpDirty, 8'h00, 16'h0000, 5'd5);   // dirty but never valid
    send_request(bbc_pkg::OpDirty, 8'h00, 16'h0000, 5'd31);  // out of range
    send_request(bbc_pkg::OpRelease, 8'h00, 16'h0000, 5'd30); // out of range
    send_request(bbc_pkg::OpSync, 8'hA5, 16'h5A5A, 5'd7);
    send_request(bbc_pkg::OpRelease, 8'h00, 16'h0000, 5'd0);
    send_request(bbc_pkg::OpRelease, 8'h00, 16'h0000, 5'd0); // releases the last reference
    send_request(bbc_pkg::OpDirty, 8'h00, 16'h0000, 5'd0);
    send_request(bbc_pkg::OpGet, 8'h12, 16'h1234, 5'd0);     // reuse dirty slot 0
    wait_drained();

    // fill every slot, then miss with none free
    for (int i = 0; i < SlotCount; i++)
      send_request(bbc_pkg::OpGet, 8'h40, 16'(1000 + i), 5'd0);
    send_request(bbc_pkg::OpGet, 8'h41, 16'h7777, 5'd0);
    for (int i = 0; i < SlotCount; i++)
      send_request(bbc_pkg::OpDirty, 8'h0, 16'h0, 5'(i));
    send_request(bbc_pkg::OpSync, 8'h0, 16'h0, 5'd0);
    for (int i = 0; i < SlotCount; i++)
      send_request(bbc_pkg::OpRelease, 8'h0, 16'h0, 5'(i));
    wait_drained();  // sender holds off until all results arrive

    // random phases: none, idle sender, stalled receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1 || phase == 3) ? 65 : (phase == 3 ? 6 : 0);
      stall_pct = (phase == 2) ? 65 : (phase == 3 ? 6 : 0);
      if (phase == 3) idle_pct = 6;
      for (int i = 0; i < 28; i++) random_request();
    end
    wait_drained();

    $display("Sent %0d requests, checked %0d results: %0d hits, %0d writebacks, %0d full",
             sent_count, result_count, hit_count, wb_count, no_free_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
